@@ rtl/core/ssu_pkg.sv @@
// Shared types, constants and helpers of the substring search unit.
package ssu_pkg;

  localparam int unsigned NEEDLE_MAX_DEF = 16;
  localparam int unsigned TEXT_MAX_DEF   = 65535;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned POS_W          = 16;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_NEEDLE = 2'd1,
    REQ_TEXT   = 2'd2,
    REQ_END    = 2'd3
  } ssu_req_e;

  // Per-cycle control broadcast along the cell chain.
  typedef struct packed {
    logic text_shift;
    logic needle_shift;
    logic fold_en;
  } ssu_ctrl_t;

  // Fold ASCII upper case to lower case when enabled.
  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c,
                                                  input logic en);
    logic [BYTE_W-1:0] r;
    r = c;
    if (en && (c >= 8'h41) && (c <= 8'h5A)) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/ssu_cell.sv @@
// One cell of the search chain: a window byte, a needle byte and their compare.
module ssu_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ssu_pkg::ssu_ctrl_t            ctrl_i,
  input  logic                          cmp_en_i,
  input  logic [ssu_pkg::BYTE_W-1:0]    text_i,
  input  logic [ssu_pkg::BYTE_W-1:0]    needle_i,
  output logic [ssu_pkg::BYTE_W-1:0]    text_o,
  output logic [ssu_pkg::BYTE_W-1:0]    needle_o,
  output logic                          hit_o
);
  import ssu_pkg::*;

  logic [BYTE_W-1:0] text_q, text_d;
  logic [BYTE_W-1:0] needle_q, needle_d;

  assign text_d   = ctrl_i.text_shift   ? text_i   : text_q;
  assign needle_d = ctrl_i.needle_shift ? needle_i : needle_q;

  // Window byte resets to zero; the needle byte is undefined until written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_q <= '0;
    end else begin
      text_q <= text_d;
    end
  end

  always_ff @(posedge clk_i) begin
    needle_q <= needle_d;
  end

  assign text_o   = text_q;
  assign needle_o = needle_q;
  // Cells beyond the needle length do not take part.
  assign hit_o = !cmp_en_i ||
                 (fold_byte(text_q, ctrl_i.fold_en) == fold_byte(needle_q, ctrl_i.fold_en));

endmodule

@@ rtl/core/substring_search_unit.sv @@
// Top level of the substring search unit: request decode, cell chain and result register.
//
// Usage: load a needle, stream a text, read one result word.
// Input channel (in_valid_i / in_stall_o) carries one word per item: req_type_i
// selects clear, needle byte, text byte or end of text, data_byte_i carries the byte.
// A clear empties the needle and the search. Needle bytes enter a chain of
// NEEDLE_MAX cells in reverse order, so cell j holds the needle byte that lines up
// with the j-th newest text byte. Each text byte shifts the window chain by one
// cell; the next cycle every cell compares its pair and the hits are ANDed.
// An end-of-text word produces one result word on the output channel
// (out_valid_o / out_stall_i): found, match position, needle and text overflow.
// Throughput: one word per cycle. The result is registered and appears in the cycle
// after the end-of-text word is accepted; the pending compare of the last text byte is
// folded into that result directly.
// The output register holds a result while the receiver stalls; the input is
// stalled for as long as that result waits, then words flow again at full rate.
// Reset clears the needle length, the search state, the result valid flag and
// ignore_case; no clearing pass is needed. Write ignore_case only while idle.
module substring_search_unit #(
  parameter int unsigned NEEDLE_MAX = ssu_pkg::NEEDLE_MAX_DEF,
  parameter int unsigned TEXT_MAX   = ssu_pkg::TEXT_MAX_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ssu_pkg::ssu_req_e             req_type_i,
  input  logic [ssu_pkg::BYTE_W-1:0]    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          found_o,
  output logic [ssu_pkg::POS_W-1:0]     match_position_o,
  output logic                          needle_overflow_o,
  output logic                          text_overflow_o
);
  import ssu_pkg::*;

  localparam int unsigned LEN_W = $clog2(NEEDLE_MAX + 1);
  localparam int unsigned CNT_W = $clog2(64'(TEXT_MAX) + 64'd2);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(64'(TEXT_MAX));
  localparam logic [CNT_W-1:0] CNT_OVFL = CNT_W'(64'(TEXT_MAX) + 64'd1);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(NEEDLE_MAX);

  // Control and search state.
  logic              ignore_case_q;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              too_long_q, too_long_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              seen_q, seen_d;
  logic [POS_W-1:0]  start_q, start_d;
  logic              check_q, check_d;
  logic [POS_W-1:0]  pend_pos_q, pend_pos_d;

  // Result register.
  logic              out_valid_q, out_valid_d;
  logic              found_q, found_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              nov_q, nov_d;
  logic              tov_q, tov_d;

  logic              in_acc;
  ssu_ctrl_t         ctrl;
  logic              win_ok;
  logic              seen_eff;
  logic [POS_W-1:0]  start_eff;
  logic [CNT_W-1:0]  count_inc;
  logic [63:0]       pos_diff;

  logic [BYTE_W-1:0]     text_chain   [NEEDLE_MAX];
  logic [BYTE_W-1:0]     needle_chain [NEEDLE_MAX];
  logic [NEEDLE_MAX-1:0] cell_hit;
  logic [NEEDLE_MAX-1:0] cell_en;

  // Stall only when a result is waiting and cannot leave this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Shift the window on an in-range text byte; shift the needle while room is left.
  always_comb begin
    ctrl.text_shift   = in_acc && (req_type_i == REQ_TEXT) && (count_q < CNT_MAX);
    ctrl.needle_shift = in_acc && (req_type_i == REQ_NEEDLE) && (len_q < LEN_FULL);
    ctrl.fold_en      = ignore_case_q;
  end

  // Cell chain: cell 0 takes the new byte, each cell hands its bytes onward.
  for (genvar j = 0; j < NEEDLE_MAX; j++) begin : g_cell
    logic [BYTE_W-1:0] t_in, n_in;
    if (j == 0) begin : g_head
      assign t_in = data_byte_i;
      assign n_in = data_byte_i;
    end else begin : g_body
      assign t_in = text_chain[j-1];
      assign n_in = needle_chain[j-1];
    end
    assign cell_en[j] = (LEN_W'(j) < len_q);
    ssu_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .cmp_en_i (cell_en[j]),
      .text_i   (t_in),
      .needle_i (n_in),
      .text_o   (text_chain[j]),
      .needle_o (needle_chain[j]),
      .hit_o    (cell_hit[j])
    );
  end

  assign win_ok = &cell_hit;

  // Resolve the compare of the previous text byte.
  assign seen_eff  = seen_q || (check_q && win_ok);
  assign start_eff = (!seen_q && check_q && win_ok) ? pend_pos_q : start_q;

  assign count_inc = count_q + CNT_W'(1);
  assign pos_diff  = 64'(count_inc) - 64'(len_q);

  always_comb begin
    len_d      = len_q;
    too_long_d = too_long_q;
    count_d    = count_q;
    seen_d     = seen_eff;
    start_d    = start_eff;
    check_d    = 1'b0;
    pend_pos_d = pend_pos_q;
    if (in_acc) begin
      unique case (req_type_i)
        REQ_CLEAR: begin
          len_d      = '0;
          too_long_d = 1'b0;
          count_d    = '0;
          seen_d     = 1'b0;
          start_d    = '0;
        end
        REQ_NEEDLE: begin
          if (len_q < LEN_FULL) begin
            len_d = len_q + LEN_W'(1);
          end else begin
            too_long_d = 1'b1;
          end
          count_d = '0;
          seen_d  = 1'b0;
          start_d = '0;
        end
        REQ_TEXT: begin
          if (count_q >= CNT_MAX) begin
            // Drop bytes past the text limit and flag the overflow.
            count_d = CNT_OVFL;
          end else begin
            count_d    = count_inc;
            check_d    = !too_long_q && (len_q != '0) && (count_inc >= CNT_W'(len_q));
            pend_pos_d = pos_diff[POS_W-1:0];
          end
        end
        REQ_END: begin
          count_d = '0;
          seen_d  = 1'b0;
          start_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register: load on end of text, drop once taken.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    found_d     = found_q;
    pos_d       = pos_q;
    nov_d       = nov_q;
    tov_d       = tov_q;
    if (in_acc && (req_type_i == REQ_END)) begin
      out_valid_d = 1'b1;
      found_d     = !too_long_q && ((len_q == '0) || seen_eff);
      pos_d       = (!too_long_q && (len_q != '0) && seen_eff) ? start_eff : '0;
      nov_d       = too_long_q;
      tov_d       = (count_q > CNT_MAX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ignore_case_q <= 1'b0;
      len_q         <= '0;
      too_long_q    <= 1'b0;
      count_q       <= '0;
      seen_q        <= 1'b0;
      start_q       <= '0;
      check_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ignore_case_q <= cfg_wdata_i;
      end
      len_q       <= len_d;
      too_long_q  <= too_long_d;
      count_q     <= count_d;
      seen_q      <= seen_d;
      start_q     <= start_d;
      check_q     <= check_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_pos_q <= pend_pos_d;
    found_q    <= found_d;
    pos_q      <= pos_d;
    nov_q      <= nov_d;
    tov_q      <= tov_d;
  end

  assign out_valid_o       = out_valid_q;
  assign found_o           = found_q;
  assign match_position_o  = pos_q;
  assign needle_overflow_o = nov_q;
  assign text_overflow_o   = tov_q;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench of the substring search unit: directed table and random jobs.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssu_pkg::*;

  localparam int unsigned NMAX = NEEDLE_MAX_DEF;
  localparam int unsigned TMAX = TEXT_MAX_DEF;

  // One search outcome as it leaves the block.
  typedef struct packed {
    logic        found;
    logic [15:0] pos;
    logic        novf;
    logic        tovf;
  } outcome_t;

  // One row of the directed table; typed rows carry their outcome inline.
  typedef struct packed {
    ssu_req_e    req;
    logic [7:0]  data;
    logic        typed;
    outcome_t    want;
  } smoke_row_t;

  localparam outcome_t NONE     = '{1'b0, 16'd0, 1'b0, 1'b0};
  localparam outcome_t HIT_AT_0 = '{1'b1, 16'd0, 1'b0, 1'b0};

  // Walk clear, needle and text words through the plain cases:
  // empty needle on empty text, a hit, a needle longer than the text, a needle byte in
  // the middle of a text, a case mismatch without folding, a zero byte as needle and text.
  localparam smoke_row_t SMOKE_ROWS [25] = '{
    '{REQ_END,    8'h00, 1'b1, HIT_AT_0},
    '{REQ_CLEAR,  8'hFF, 1'b0, NONE},
    '{REQ_END,    8'hAA, 1'b1, HIT_AT_0},
    '{REQ_NEEDLE, 8'h41, 1'b0, NONE},
    '{REQ_NEEDLE, 8'h62, 1'b0, NONE},
    '{REQ_TEXT,   8'h00, 1'b0, NONE},
    '{REQ_TEXT,   8'h41, 1'b0, NONE},
    '{REQ_TEXT,   8'h62, 1'b0, NONE},
    '{REQ_END,    8'h55, 1'b1, '{1'b1, 16'd1, 1'b0, 1'b0}},
    '{REQ_TEXT,   8'h41, 1'b0, NONE},
    '{REQ_END,    8'h00, 1'b1, NONE},
    '{REQ_TEXT,   8'h41, 1'b0, NONE},
    '{REQ_NEEDLE, 8'hFF, 1'b0, NONE},
    '{REQ_TEXT,   8'h41, 1'b0, NONE},
    '{REQ_TEXT,   8'h62, 1'b0, NONE},
    '{REQ_TEXT,   8'hFF, 1'b0, NONE},
    '{REQ_END,    8'hFF, 1'b1, HIT_AT_0},
    '{REQ_TEXT,   8'h61, 1'b0, NONE},
    '{REQ_TEXT,   8'h42, 1'b0, NONE},
    '{REQ_TEXT,   8'hFF, 1'b0, NONE},
    '{REQ_END,    8'h00, 1'b1, NONE},
    '{REQ_CLEAR,  8'h00, 1'b0, NONE},
    '{REQ_NEEDLE, 8'h00, 1'b0, NONE},
    '{REQ_TEXT,   8'h00, 1'b0, NONE},
    '{REQ_END,    8'h00, 1'b1, HIT_AT_0}
  };

  // Byte pools that make hits likely and sit on both sides of the fold range.
  localparam bit [7:0] LETTERS [4]     = '{8'h61, 8'h41, 8'h62, 8'h42};
  localparam bit [7:0] FOLD_BOUNDS [6] = '{8'h40, 8'h5A, 8'h5B, 8'h60, 8'h7A, 8'h7B};

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  ssu_req_e   req_type_i  = REQ_CLEAR;
  logic [7:0] data_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       found_o;
  logic [15:0] match_position_o;
  logic       needle_overflow_o;
  logic       text_overflow_o;

  substring_search_unit u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type_i),
    .data_byte_i       (data_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .found_o           (found_o),
    .match_position_o  (match_position_o),
    .needle_overflow_o (needle_overflow_o),
    .text_overflow_o   (text_overflow_o)
  );

  // Shadow copy of the search state, updated as words are accepted.
  bit [7:0]    ndl [NMAX];
  int unsigned ndl_len   = 0;
  bit          ndl_ovf   = 1'b0;
  bit [7:0]    win [NMAX];
  int unsigned txt_cnt   = 0;
  bit          hit_seen  = 1'b0;
  bit [15:0]   hit_at    = '0;
  bit          fold_on   = 1'b0;

  outcome_t    search_outcomes [$];
  bit [7:0]    job_needle [$];
  int unsigned words_sent   = 0;
  int unsigned err_count    = 0;
  bit          quiet        = 1'b0;
  bit          hold_off_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic bit [7:0] to_lower(bit [7:0] c);
    if (fold_on && c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  // Compare the newest ndl_len text bytes with the needle, oldest byte first.
  function automatic bit window_hit();
    for (int unsigned i = 0; i < ndl_len; i++) begin
      if (to_lower(win[ndl_len - 1 - i]) != to_lower(ndl[i])) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void restart_text();
    foreach (win[k]) win[k] = 8'h00;
    txt_cnt  = 0;
    hit_seen = 1'b0;
    hit_at   = '0;
  endfunction

  // Advance the shadow state by one word; return 1 when the word yields an outcome.
  function automatic bit predict_search(ssu_req_e req, bit [7:0] b, output outcome_t r);
    r = '0;
    case (req)
      REQ_CLEAR: begin
        ndl_len = 0;
        ndl_ovf = 1'b0;
        restart_text();
      end
      REQ_NEEDLE: begin
        // Drop bytes past the cell chain, but remember that they came.
        if (ndl_len < NMAX) begin
          ndl[ndl_len] = b;
          ndl_len++;
        end else begin
          ndl_ovf = 1'b1;
        end
        // Restart the search; the window keeps its bytes.
        txt_cnt  = 0;
        hit_seen = 1'b0;
        hit_at   = '0;
      end
      REQ_TEXT: begin
        if (txt_cnt >= TMAX) begin
          txt_cnt = TMAX + 1;
        end else begin
          for (int k = NMAX - 1; k > 0; k--) win[k] = win[k - 1];
          win[0] = b;
          txt_cnt++;
          if (!hit_seen && !ndl_ovf && ndl_len > 0 && txt_cnt >= ndl_len && window_hit()) begin
            hit_seen = 1'b1;
            hit_at   = 16'(txt_cnt - ndl_len);
          end
        end
      end
      default: begin
        r.found = !ndl_ovf && (ndl_len == 0 || hit_seen);
        r.pos   = (r.found && ndl_len > 0) ? hit_at : 16'd0;
        r.novf  = ndl_ovf;
        r.tovf  = txt_cnt > TMAX;
        restart_text();
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // Offer one word, idling at random first; hold it until the block takes it.
  task automatic send_word(ssu_req_e req, bit [7:0] b, bit typed = 1'b0,
                           outcome_t want = '0);
    outcome_t r;
    bit       yields;
    while (!quiet && $urandom_range(0, 99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    yields = predict_search(req, b, r);
    if (yields) search_outcomes.push_back(typed ? want : r);
    words_sent++;
  endtask

  // Drop valid and wait until every outcome is back and the block is idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (search_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_ignore_case(bit v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    fold_on = v;
    cfg_we_i <= 1'b0;
  endtask

  function automatic bit [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return LETTERS[$urandom_range(0, 3)];
    if (r < 7) return FOLD_BOUNDS[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic bit [7:0] swap_case(bit [7:0] c);
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) return c ^ 8'h20;
    return c;
  endfunction

  // One search job: maybe a new needle, a text that may hold a planted copy, end of text.
  // A few jobs are plain noise: random words of any type.
  task automatic run_job();
    int unsigned nlen;
    int unsigned tlen;
    int unsigned spot;
    int unsigned cut;
    int unsigned r;
    bit [7:0]    b;
    bit [7:0]    txt [$];
    if ($urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 3)) begin
        send_word(ssu_req_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
      return;
    end
    if (job_needle.size() == 0 || $urandom_range(0, 99) < 40) begin
      r = $urandom_range(0, 99);
      if (r < 8) nlen = 0;
      else if (r < 16) nlen = $urandom_range(NMAX + 1, NMAX + 4);
      else if (r < 26) nlen = $urandom_range(5, NMAX);
      else nlen = $urandom_range(1, 4);
      send_word(REQ_CLEAR, 8'($urandom_range(0, 255)));
      job_needle.delete();
      repeat (nlen) begin
        b = pick_byte();
        job_needle.push_back(b);
        send_word(REQ_NEEDLE, b);
      end
    end
    tlen = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 30);
    repeat (tlen) txt.push_back(pick_byte());
    // Plant the needle, flipping the case of some letters.
    if ($urandom_range(0, 99) < 60 && job_needle.size() > 0 &&
        job_needle.size() <= NMAX && job_needle.size() <= tlen) begin
      spot = $urandom_range(0, tlen - job_needle.size());
      foreach (job_needle[i]) begin
        txt[spot + i] = ($urandom_range(0, 99) < 30) ? swap_case(job_needle[i]) : job_needle[i];
      end
    end
    // Now and then slip a needle byte into the text.
    cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, tlen) : tlen + 1;
    for (int unsigned i = 0; i < tlen; i++) begin
      if (i == cut) begin
        b = pick_byte();
        job_needle.push_back(b);
        send_word(REQ_NEEDLE, b);
      end
      send_word(REQ_TEXT, txt[i]);
    end
    send_word(REQ_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic run_phase(int unsigned words);
    int unsigned goal;
    goal = words_sent + words;
    while (words_sent < goal) run_job();
  endtask

  // Receiver: stall at random, or hold off for a long stretch when asked.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(0, 99) < 28);
      end
    end
  end

  // Check each accepted result word against the oldest outcome waiting.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (search_outcomes.size() == 0) begin
        $error("result word with no outcome waiting");
        err_count++;
      end else begin
        want = search_outcomes.pop_front();
        if (found_o !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found_o);
          err_count++;
        end
        if (match_position_o !== want.pos) begin
          $error("match_position: expected %0d, got %0d", want.pos, match_position_o);
          err_count++;
        end
        if (needle_overflow_o !== want.novf) begin
          $error("needle_overflow: expected %0d, got %0d", want.novf, needle_overflow_o);
          err_count++;
        end
        if (text_overflow_o !== want.tovf) begin
          $error("text_overflow: expected %0d, got %0d", want.tovf, text_overflow_o);
          err_count++;
        end
      end
    end
  end

  initial begin
    foreach (ndl[k]) ndl[k] = 8'h00;
    foreach (win[k]) win[k] = 8'h00;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (SMOKE_ROWS[i]) begin
      send_word(SMOKE_ROWS[i].req, SMOKE_ROWS[i].data, SMOKE_ROWS[i].typed,
                SMOKE_ROWS[i].want);
    end
    settle();

    // Folding on, normal idling.
    set_ignore_case(1'b1);
    run_phase(360);
    settle();

    // Folding off, no idling on either side.
    set_ignore_case(1'b0);
    quiet = 1'b1;
    run_phase(360);
    settle();
    quiet = 1'b0;

    // Folding on; the receiver holds off so the block backs up into the input.
    set_ignore_case(1'b1);
    hold_off_req = 1'b1;
    run_phase(360);
    settle();

    set_ignore_case(1'b0);
    run_phase(370);
    settle();

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/ssu_pkg.sv
rtl/core/ssu_cell.sv
rtl/core/substring_search_unit.sv
tb/tb.sv
